// ===== sv/mcf_pkg.sv =====
// mcf_pkg: shared types and constants for the message chunk framer
// opcode and register index codes, controller/datapath command and status structs
// no dependencies

package mcf_pkg;

    // input opcode codes (carried on s_axis_tuser)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic CFG_NODE_ID  = 1'b0;
    localparam logic CFG_SEQ_TAG  = 1'b1;

    // fixed field widths
    localparam int HDR_BYTES    = 8;
    localparam int NODE_W       = 7;
    localparam int SEQ_W        = 16;
    localparam int MSG_W        = 32;
    localparam int CHUNK_W      = 8;
    localparam int CFG_DATA_W   = 16;

    // controller to datapath commands
    typedef struct packed {
        logic msg_start;   // new message: bump message counter, clear chunk and fill
        logic append;      // write the input byte into the payload store
        logic begin_emit;  // capture last flag, rewind the byte index
        logic emit_last;   // last-chunk flag for the packet being started
        logic load;        // move the next packet byte into the output register
        logic finish;      // final byte loaded: bump chunk, reset fill
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full_next;   // one more byte fills the packet
        logic slot_free;   // output register can take a byte this cycle
        logic final_idx;   // byte index points at the last packet byte
    } t_dp_status;

endpackage

// ===== sv/mcf_datapath.sv =====
// mcf_datapath: counters, config registers, payload memory and output register
// executes commands from mcf_ctrl, reports status back
// depends on mcf_pkg

module mcf_datapath #(
    parameter int PACKET_BYTES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mcf_pkg::t_dp_cmd             i_cmd,
    output mcf_pkg::t_dp_status          o_status,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [mcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [7:0]                   o_out_byte,
    output logic                         o_out_last
);

    localparam int DEPTH = PACKET_BYTES - mcf_pkg::HDR_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(PACKET_BYTES + 1);
    localparam logic [IW-1:0] HDR     = IW'(mcf_pkg::HDR_BYTES);
    localparam logic [IW-1:0] FULL_M1 = IW'(PACKET_BYTES - 1);

    logic [7:0]                   r_mem [DEPTH];
    logic [7:0]                   r_rd_data;
    logic [IW-1:0]                r_fill, n_fill;
    logic [IW-1:0]                r_idx, n_idx;
    logic [mcf_pkg::MSG_W-1:0]    r_msg_cnt;
    logic [mcf_pkg::CHUNK_W-1:0]  r_chunk_cnt;
    logic [mcf_pkg::NODE_W-1:0]   r_node_id;
    logic [mcf_pkg::SEQ_W-1:0]    r_seq_tag;
    logic                         r_last;
    logic                         r_out_valid;
    logic [7:0]                   r_out_byte;
    logic                         r_out_last;

    logic [IW-1:0]  rd_off;
    logic [IW-1:0]  wr_off;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [63:0]    hdr;
    logic [7:0]     hdr_byte;
    logic [7:0]     byte_sel;

    // next fill level and byte index
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.msg_start || i_cmd.finish) begin
            n_fill = HDR;
        end else if (i_cmd.append) begin
            n_fill = r_fill + IW'(1);
        end
        n_idx = r_idx;
        if (i_cmd.begin_emit) begin
            n_idx = '0;
        end else if (i_cmd.load) begin
            n_idx = r_idx + IW'(1);
        end
    end

    // read address follows the index after this cycle, so read data lines up with r_idx
    assign rd_off  = n_idx - HDR;
    assign rd_addr = rd_off[AW-1:0];
    assign wr_off  = r_fill - HDR;
    assign wr_addr = wr_off[AW-1:0];

    assign hdr      = {r_node_id, r_seq_tag, r_msg_cnt, r_chunk_cnt, r_last};
    assign hdr_byte = hdr[{r_idx[2:0], 3'b000} +: 8];
    assign byte_sel = (r_idx < HDR) ? hdr_byte : r_rd_data;

    assign o_status.full_next = (r_fill == FULL_M1);
    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.final_idx = (r_idx == (r_fill - IW'(1)));

    // payload memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[wr_addr] <= i_data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // byte index, last flag and output registers (not reset)
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.begin_emit) begin
            r_last <= i_cmd.emit_last;
        end
        if (i_cmd.load) begin
            r_out_byte <= byte_sel;
            r_out_last <= o_status.final_idx;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= HDR;
            r_msg_cnt   <= '0;
            r_chunk_cnt <= '0;
            r_node_id   <= '0;
            r_seq_tag   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.msg_start) begin
                r_msg_cnt   <= r_msg_cnt + 32'd1;
                r_chunk_cnt <= '0;
            end else if (i_cmd.finish) begin
                r_chunk_cnt <= r_chunk_cnt + 8'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mcf_pkg::CFG_NODE_ID: r_node_id <= i_cfg_data[mcf_pkg::NODE_W-1:0];
                    mcf_pkg::CFG_SEQ_TAG: r_seq_tag <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ===== sv/mcf_ctrl.sv =====
// mcf_ctrl: two-state controller, takes requests and sequences packet output
// drives mcf_datapath through command and status structs
// depends on mcf_pkg

module mcf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic                 i_eom,
    input  mcf_pkg::t_dp_status  i_status,
    output mcf_pkg::t_dp_cmd     o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state, n_state;
    logic acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (i_opcode)
                        mcf_pkg::OP_START: o_cmd.msg_start = 1'b1;
                        mcf_pkg::OP_DATA: begin
                            o_cmd.append = 1'b1;
                            if (i_status.full_next || i_eom) begin
                                o_cmd.begin_emit = 1'b1;
                                o_cmd.emit_last  = i_eom;
                                n_state          = ST_EMIT;
                            end
                        end
                        mcf_pkg::OP_CLOSE: begin
                            o_cmd.begin_emit = 1'b1;
                            o_cmd.emit_last  = 1'b1;
                            n_state          = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.final_idx) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/message_chunk_framer.sv =====
// message_chunk_framer: cuts a message byte stream into packets of at most PACKET_BYTES bytes
// a closing item starts emission; its first header byte loads once the output register is free
// throughput: one cycle per request that emits nothing; a closing request holds s_axis until
// its last packet byte (8 header + payload) is loaded into the single output register
// reset (synchronous, i_rst_n low): state, message/chunk counters, config, out valid cleared;
// fill to header size; payload memory is not cleared and is only ever read after being written

module message_chunk_framer #(
    parameter int PACKET_BYTES = 32   // total packet size in bytes, 9 to 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        s_axis_tlast,   // end_of_message
    // packet bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // end_of_packet
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,    // 0 node_id, 1 sequence_tag
    input  logic [15:0] i_cfg_data
);

    mcf_pkg::t_dp_cmd    cmd;
    mcf_pkg::t_dp_status status;

    // controller: accepts requests while idle, paces output loads while emitting
    mcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_opcode   (s_axis_tuser),
        .i_eom      (s_axis_tlast),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: header fields, payload memory, byte index and output register
    mcf_datapath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_data_byte (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// ===== verif/message_chunk_framer_test.sv =====
// message_chunk_framer_test: self-checking bench for the message chunk framer
// drives requests and config writes, predicts every packet byte, compares in order
// depends on mcf_pkg and message_chunk_framer
`timescale 1ns / 1ps

module message_chunk_framer_test;

    localparam int PKT_BYTES = 32;
    localparam int PAY_BYTES = PKT_BYTES - mcf_pkg::HDR_BYTES;
    // the one opcode the block drops without any effect
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles to let the block settle after the last byte before config writes or the end
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data;
        logic       eom;
        logic       hold;   // wait for every outstanding packet byte before sending
    } t_request;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_pkt_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
    logic        s_axis_tlast = 1'b0; // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] out_byte
    logic        m_axis_tlast;        // end_of_packet
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = mcf_pkg::CFG_NODE_ID;
    logic [mcf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    message_chunk_framer #(
        .PACKET_BYTES(PKT_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // framer state as the bench sees it
    // ------------------------------------------------------------------
    logic [mcf_pkg::NODE_W-1:0]  fr_node = '0;
    logic [mcf_pkg::SEQ_W-1:0]   fr_seq = '0;
    logic [7:0]                  fr_payload [PAY_BYTES];
    int                          fr_fill = mcf_pkg::HDR_BYTES;
    logic [mcf_pkg::MSG_W-1:0]   fr_msg = '0;
    logic [mcf_pkg::CHUNK_W-1:0] fr_chunk = '0;

    t_request  req_q[$];        // requests waiting for the driver
    t_pkt_byte pkt_bytes_due[$]; // packet bytes still to come out, oldest first

    int errors = 0;
    int n_req = 0;
    int n_bytes = 0;
    int n_packets = 0;
    int n_hdr_only = 0;
    int n_msgs = 0;

    // header goes out lsb first: node, tag, message, chunk, last flag from the top down
    task automatic emit_packet(input logic last);
        logic [63:0] hdr;
        t_pkt_byte   b;
        hdr = {fr_node, fr_seq, fr_msg, fr_chunk, last};
        for (int i = 0; i < fr_fill; i++) begin
            b.data = (i < mcf_pkg::HDR_BYTES) ? hdr[8*i +: 8]
                                              : fr_payload[i - mcf_pkg::HDR_BYTES];
            b.last = (i == fr_fill - 1);
            pkt_bytes_due.push_back(b);
        end
        n_packets++;
        if (fr_fill == mcf_pkg::HDR_BYTES)
            n_hdr_only++;
        fr_chunk++;
        fr_fill = mcf_pkg::HDR_BYTES;
    endtask

    // advance the framer by one accepted request and queue the bytes it releases
    task automatic frame_request(input t_request r);
        case (r.opcode)
            mcf_pkg::OP_START: begin
                fr_msg++;
                fr_chunk = '0;
                fr_fill = mcf_pkg::HDR_BYTES;
                n_msgs++;
            end
            mcf_pkg::OP_DATA: begin
                if (fr_fill < PKT_BYTES) begin
                    fr_payload[fr_fill - mcf_pkg::HDR_BYTES] = r.data;
                    fr_fill++;
                end
                if (fr_fill >= PKT_BYTES || r.eom)
                    emit_packet(r.eom);
            end
            mcf_pkg::OP_CLOSE: emit_packet(1'b1);
            default: ;   // unused opcode leaves everything alone
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on packet byte %0d: %s got 0x%0h want 0x%0h",
                 $realtime, n_bytes, what, got, want);
        errors++;
    endtask

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    t_request cur_req;
    logic     req_open = 1'b0;  // a request is on the bus and not yet taken
    int       tx_gap = 0;
    logic     tx_calm = 1'b0;   // stretch with no gaps at all

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                frame_request(cur_req);
                n_req++;
                req_open = 1'b0;
            end
            if ($urandom_range(0, 47) == 0)
                tx_calm = ~tx_calm;
            if (!req_open) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0 &&
                             !(req_q[0].hold && pkt_bytes_due.size() > 0)) begin
                    cur_req = req_q.pop_front();
                    req_open = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_req.data;
                    s_axis_tuser  <= cur_req.opcode;
                    s_axis_tlast  <= cur_req.eom;
                    tx_gap = tx_calm ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // packet byte monitor with random back pressure
    // ------------------------------------------------------------------
    int        rx_stall = 0;
    logic      rx_calm = 1'b0;
    t_pkt_byte want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pkt_bytes_due.size() == 0) begin
                    report_mismatch("unexpected byte", int'(m_axis_tdata), 0);
                end else begin
                    want = pkt_bytes_due.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch("out_byte", int'(m_axis_tdata), int'(want.data));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("end_of_packet", int'(m_axis_tlast),
                                        int'(want.last));
                end
                n_bytes++;
            end
            if ($urandom_range(0, 63) == 0)
                rx_calm = ~rx_calm;
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_stall = rx_calm ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] op, input logic [7:0] data,
                             input logic eom, input logic hold);
        t_request r;
        r.opcode = op;
        r.data   = data;
        r.eom    = eom;
        r.hold   = hold;
        req_q.push_back(r);
    endtask

    // everything sent, every byte back, then a settling wait for the block to go quiet
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (req_q.size() > 0 || req_open || pkt_bytes_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [mcf_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == mcf_pkg::CFG_NODE_ID)
            fr_node = val[mcf_pkg::NODE_W-1:0];
        else
            fr_seq = val[mcf_pkg::SEQ_W-1:0];
    endtask

    task automatic set_header_fields(input int node, input int seq);
        write_reg(mcf_pkg::CFG_NODE_ID, mcf_pkg::CFG_DATA_W'(node));
        write_reg(mcf_pkg::CFG_SEQ_TAG, mcf_pkg::CFG_DATA_W'(seq));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one message: mostly well formed with random content, some noise
    // returns how many requests that the block acts on were queued
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 10);
        if (r < 85)
            return $urandom_range(11, 30);
        return PAY_BYTES * $urandom_range(1, 2);   // exactly fills packets
    endfunction

    task automatic queue_message(input logic hold, output int used);
        int len;
        int ending;
        used = 0;
        if ($urandom_range(0, 99) < 15) begin
            // noise: ignored opcode, stray close, data with no fresh start, double start
            case ($urandom_range(0, 3))
                0: queue_req(OP_UNUSED, 8'($urandom), 1'($urandom), hold);
                1: begin
                    queue_req(mcf_pkg::OP_CLOSE, 8'($urandom), 1'($urandom), hold);
                    used = 1;
                end
                2: begin
                    queue_req(mcf_pkg::OP_DATA, 8'($urandom), 1'b0, hold);
                    queue_req(mcf_pkg::OP_DATA, 8'($urandom), 1'b1, 1'b0);
                    used = 2;
                end
                default: begin
                    queue_req(mcf_pkg::OP_START, 8'($urandom), 1'($urandom), hold);
                    queue_req(mcf_pkg::OP_START, 8'($urandom), 1'($urandom), 1'b0);
                    used = 2;
                end
            endcase
            return;
        end
        queue_req(mcf_pkg::OP_START, 8'($urandom), 1'($urandom), hold);
        len = pick_len();
        ending = $urandom_range(0, 99);
        for (int i = 0; i < len; i++) begin
            // last byte carries the end mark unless the message closes separately
            queue_req(mcf_pkg::OP_DATA, 8'($urandom), (i == len - 1) && (ending < 60),
                      $urandom_range(0, 99) < 3);
        end
        used = len + 1;
        if (ending >= 60) begin
            queue_req(mcf_pkg::OP_CLOSE, 8'($urandom), 1'($urandom), 1'b0);
            used++;
            if (ending >= 85) begin
                // second close finds nothing held: header-only packet
                queue_req(mcf_pkg::OP_CLOSE, 8'($urandom), 1'($urandom), 1'b0);
                used++;
            end
        end
        // now and then a start cuts a message short, dropping its partial payload
        if ($urandom_range(0, 99) < 10) begin
            queue_req(mcf_pkg::OP_START, 8'($urandom), 1'($urandom), 1'b0);
            queue_req(mcf_pkg::OP_DATA, 8'($urandom), 1'b0, 1'b0);
            queue_req(mcf_pkg::OP_START, 8'($urandom), 1'($urandom), 1'b0);
            used += 3;
        end
    endtask

    task automatic queue_random_phase(input int budget);
        int used;
        int total;
        total = 0;
        while (total < budget) begin
            // first message of a phase waits for the pipe to drain
            queue_message(total == 0 || $urandom_range(0, 99) < 10, used);
            total += used;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // all header fields at their top values
        set_header_fields(127, 'hFFFF);

        // directed: corner cases with all-ones header fields
        queue_req(mcf_pkg::OP_DATA, 8'hFF, 1'b1, 1'b0);     // data before any start
        queue_req(mcf_pkg::OP_CLOSE, 8'h5A, 1'b0, 1'b0);    // close with nothing held
        queue_req(OP_UNUSED, 8'hAA, 1'b1, 1'b0);            // ignored opcode
        queue_req(mcf_pkg::OP_START, 8'h55, 1'b1, 1'b0);
        queue_req(mcf_pkg::OP_DATA, 8'h00, 1'b0, 1'b0);
        queue_req(mcf_pkg::OP_DATA, 8'hFF, 1'b0, 1'b0);
        queue_req(mcf_pkg::OP_DATA, 8'hA5, 1'b0, 1'b0);
        queue_req(mcf_pkg::OP_CLOSE, 8'h00, 1'b1, 1'b1);    // partial payload, last flag set
        queue_req(mcf_pkg::OP_START, 8'hFF, 1'b0, 1'b0);
        queue_req(mcf_pkg::OP_START, 8'h00, 1'b0, 1'b0);    // back-to-back starts
        queue_req(mcf_pkg::OP_DATA, 8'h5A, 1'b1, 1'b0);     // single-byte message
        queue_req(mcf_pkg::OP_START, 8'h0F, 1'b1, 1'b0);
        queue_req(mcf_pkg::OP_DATA, 8'h01, 1'b0, 1'b0);
        queue_req(mcf_pkg::OP_DATA, 8'h80, 1'b0, 1'b0);
        queue_req(mcf_pkg::OP_DATA, 8'h7F, 1'b0, 1'b0);
        queue_req(mcf_pkg::OP_START, 8'hF0, 1'b0, 1'b0);    // drops the three bytes above
        queue_req(mcf_pkg::OP_CLOSE, 8'hC3, 1'b0, 1'b1);    // header only after the drop
        queue_req(mcf_pkg::OP_DATA, 8'h3C, 1'b1, 1'b0);
        wait_idle();

        // random phases, each under its own header settings
        set_header_fields(0, 0);
        queue_random_phase(16);
        wait_idle();
        set_header_fields($urandom_range(0, 127), $urandom_range(0, 'hFFFF));
        queue_random_phase(16);
        wait_idle();
        set_header_fields(127, 0);
        queue_random_phase(16);
        wait_idle();
        set_header_fields($urandom_range(0, 127), $urandom_range(0, 'hFFFF));
        queue_random_phase(16);
        wait_idle();

        $display("covered %0d requests over %0d messages under five header settings",
                 n_req, n_msgs);
        $display("checked %0d bytes in %0d packets, %0d of them header only",
                 n_bytes, n_packets, n_hdr_only);
        if (errors == 0) begin
            $display("PASS message_chunk_framer");
        end else begin
            $display("FAIL message_chunk_framer");
        end
        $finish;
    end

    // watchdog well past the slowest legal run
    initial begin
        #16_000_000;
        $display("timeout with %0d packet bytes outstanding", pkt_bytes_due.size());
        $display("FAIL message_chunk_framer");
        $finish;
    end

endmodule
